// ===== hw/rtl/unicode_escape_to_utf8_core_defines.svh =====
// Assertion macros shared by the decoder's checker.
// No dependencies; include by bare file name.
`ifndef UNICODE_ESCAPE_TO_UTF8_CORE_DEFINES_SVH
`define UNICODE_ESCAPE_TO_UTF8_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UE8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ue8 check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define UE8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ue8 check failed: next-cycle implication");

`endif

// ===== hw/rtl/ue8_pkg.sv =====
// Shared types, constants and helpers for the escape-to-UTF-8 decoder.
// No dependencies.
package ue8_pkg;

    localparam logic [7:0] CHR_BSLASH      = 8'h5C;
    localparam logic [7:0] CHR_U           = 8'h75;
    localparam int         MAX_BYTES       = 6;
    localparam int         QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_ue8_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
        logic       bad_escape;
    } t_ue8_out;

    // One request from the classifier: a run of 1..6 bytes to emit.
    typedef struct packed {
        logic [2:0]                     cnt;
        logic [MAX_BYTES-1:0][7:0]      bytes;
        logic                           bad;
        logic                           last;
    } t_ue8_cmd;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ue8_front.sv =====
// Front end: escape state machine, turns accepted bytes into emit requests; bytes held in an escape give none.
// Depends on ue8_pkg.
module ue8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ue8_pkg::t_ue8_in i_item,
    output ue8_pkg::t_ue8_cmd o_cmd,
    output logic             o_cmd_valid
);
    import ue8_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BSLASH, ST_U, ST_D1, ST_D2, ST_D3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [11:0] r_accum, n_accum;
    logic        r_all_hex, n_all_hex;
    logic [7:0]  r_held [0:2];

    logic [1:0]  l_held;
    logic        l_gather;
    logic [4:0]  l_hex;
    logic [15:0] l_cp;
    t_ue8_cmd    l_cmd;
    logic [7:0]  l_b;
    logic        l_last;

    assign l_b    = i_item.in_byte;
    assign l_last = i_item.in_last;
    assign l_hex  = hex_decode(l_b);
    assign l_cp   = {r_accum, l_hex[3:0]};

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_all_hex = r_all_hex;
        l_gather  = 1'b0;
        l_held    = 2'd0;
        l_cmd     = '0;
        l_cmd.last = l_last;
        case (r_phase)
            ST_IDLE: begin
                if (l_b == CHR_BSLASH && !l_last) begin
                    n_phase = ST_BSLASH;
                end else begin
                    l_cmd.cnt      = 3'd1;
                    l_cmd.bytes[0] = l_b;
                end
            end
            ST_BSLASH: begin
                if (l_b == CHR_U) begin
                    if (l_last) begin
                        l_cmd.cnt      = 3'd2;
                        l_cmd.bytes[0] = CHR_BSLASH;
                        l_cmd.bytes[1] = CHR_U;
                        l_cmd.bad      = 1'b1;
                    end else begin
                        n_phase = ST_U;
                        n_accum = '0;
                    end
                end else if (l_b == CHR_BSLASH) begin
                    // pending backslash goes out, new one stays pending unless the string ends here
                    l_cmd.cnt      = l_last ? 3'd2 : 3'd1;
                    l_cmd.bytes[0] = CHR_BSLASH;
                    l_cmd.bytes[1] = CHR_BSLASH;
                end else begin
                    l_cmd.cnt      = 3'd2;
                    l_cmd.bytes[0] = CHR_BSLASH;
                    l_cmd.bytes[1] = l_b;
                    n_phase        = ST_IDLE;
                end
            end
            ST_U, ST_D1, ST_D2: begin
                case (r_phase)
                    ST_U:    l_held = 2'd0;
                    ST_D1:   l_held = 2'd1;
                    default: l_held = 2'd2;
                endcase
                if (l_last) begin
                    // truncated escape: everything raw and flagged
                    l_cmd.cnt      = 3'(l_held) + 3'd3;
                    l_cmd.bad      = 1'b1;
                    l_cmd.bytes[0] = CHR_BSLASH;
                    l_cmd.bytes[1] = CHR_U;
                    for (int i = 0; i < 3; i++) begin
                        l_cmd.bytes[2+i] = (i < int'(l_held)) ? r_held[i] : l_b;
                    end
                    l_cmd.bytes[5] = l_b;
                    n_phase        = ST_IDLE;
                    n_accum        = '0;
                end else begin
                    l_gather  = 1'b1;
                    n_accum   = {r_accum[7:0], l_hex[3:0] & {4{l_hex[4]}}};
                    n_all_hex = (r_phase == ST_U) ? l_hex[4] : (r_all_hex & l_hex[4]);
                    n_phase   = t_phase'(r_phase + 3'd1);
                end
            end
            ST_D3: begin
                if (r_all_hex && l_hex[4]) begin
                    if (l_cp[15:7] == '0) begin
                        l_cmd.cnt      = 3'd1;
                        l_cmd.bytes[0] = l_cp[7:0];
                    end else if (l_cp[15:11] == '0) begin
                        l_cmd.cnt      = 3'd2;
                        l_cmd.bytes[0] = {3'b110, l_cp[10:6]};
                        l_cmd.bytes[1] = {2'b10, l_cp[5:0]};
                    end else begin
                        l_cmd.cnt      = 3'd3;
                        l_cmd.bytes[0] = {4'b1110, l_cp[15:12]};
                        l_cmd.bytes[1] = {2'b10, l_cp[11:6]};
                        l_cmd.bytes[2] = {2'b10, l_cp[5:0]};
                    end
                end else begin
                    l_cmd.cnt      = 3'(MAX_BYTES);
                    l_cmd.bad      = 1'b1;
                    l_cmd.bytes[0] = CHR_BSLASH;
                    l_cmd.bytes[1] = CHR_U;
                    l_cmd.bytes[2] = r_held[0];
                    l_cmd.bytes[3] = r_held[1];
                    l_cmd.bytes[4] = r_held[2];
                    l_cmd.bytes[5] = l_b;
                end
                n_phase = ST_IDLE;
                n_accum = '0;
            end
            default: begin
                n_phase = ST_IDLE;
            end
        endcase
        if (l_last) begin
            n_phase = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_IDLE;
            r_accum   <= '0;
            r_all_hex <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_all_hex <= n_all_hex;
        end
    end

    // held characters: undefined until written, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && l_gather) begin
            r_held[l_held] <= l_b;
        end
    end

    assign o_cmd       = l_cmd;
    assign o_cmd_valid = (l_cmd.cnt != 3'd0);

endmodule

// ===== hw/rtl/ue8_queue.sv =====
// Short request queue between the classifier and the byte emitter.
// Depends on ue8_pkg.
module ue8_queue #(
    parameter int DEPTH = ue8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  ue8_pkg::t_ue8_cmd i_wdata,
    input  logic              i_rd,
    output ue8_pkg::t_ue8_cmd o_rdata,
    output logic              o_valid,
    output logic              o_full
);
    import ue8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_ue8_cmd        r_mem [0:DEPTH-1];
    logic [PW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            l_wr, l_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign l_wr    = i_wr && !o_full;
    assign l_rd    = i_rd && o_valid;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (l_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (l_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({l_wr, l_rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== hw/rtl/ue8_back.sv =====
// Back end: walks the head request into the output register one byte a cycle while popped.
// Depends on ue8_pkg.
module ue8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ue8_pkg::t_ue8_cmd i_head,
    input  logic              i_head_valid,
    output logic              o_deq,
    input  logic              i_pop,
    output logic              o_empty,
    output ue8_pkg::t_ue8_out o_result
);
    import ue8_pkg::*;

    logic [2:0] r_idx;
    logic       r_out_valid;
    t_ue8_out   r_out;
    logic       l_load, l_is_last;

    assign l_is_last = (r_idx == (i_head.cnt - 3'd1));
    // refill whenever a request waits and the output slot is free or being taken this cycle
    assign l_load    = i_head_valid && (!r_out_valid || i_pop);
    assign o_deq     = l_load && l_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (l_load) begin
                r_idx       <= l_is_last ? 3'd0 : r_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_load) begin
            r_out.out_byte   <= i_head.bytes[r_idx];
            r_out.run_last   <= l_is_last;
            r_out.string_end <= l_is_last && i_head.last;
            r_out.bad_escape <= i_head.bad;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/unicode_escape_to_utf8_core.sv =====
// Backslash-u escape to UTF-8 decoder, byte stream in and out. One input byte is
// taken per cycle while the request queue has room; the output side delivers one
// byte per cycle while the receiver pops, so a byte that expands into n results
// (a decoded escape gives 1 to 3, a raw escape up to 6) holds the output port
// until all n results are popped, and plain text flows at one byte per cycle. Input
// stalls only when multi-byte requests or a stalled receiver fill the request queue.
// The first result of a byte passes through the request queue and then the output
// register before it reaches the result ports. Surrogate halves are encoded separately;
// short or non-hex escapes pass raw with bad_escape set. Depends on ue8_pkg.
module unicode_escape_to_utf8_core #(
    parameter int QUEUE_DEPTH = ue8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  ue8_pkg::t_ue8_in  i_item,
    output logic              empty,
    input  logic              pop,
    output ue8_pkg::t_ue8_out o_result
);
    import ue8_pkg::*;

    logic     l_accept, l_cmd_valid, l_head_valid, l_deq;
    t_ue8_cmd l_cmd, l_head;

    assign l_accept = push && !full;

    ue8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (l_accept),
        .i_item     (i_item),
        .o_cmd      (l_cmd),
        .o_cmd_valid(l_cmd_valid)
    );

    ue8_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (l_accept && l_cmd_valid),
        .i_wdata(l_cmd),
        .i_rd   (l_deq),
        .o_rdata(l_head),
        .o_valid(l_head_valid),
        .o_full (full)
    );

    ue8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (l_head),
        .i_head_valid(l_head_valid),
        .o_deq       (l_deq),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== hw/rtl/ue8_checker.sv =====
// Port-level checks for the decoder, bound onto the top level.
// Depends on ue8_pkg and unicode_escape_to_utf8_core_defines.svh.
`include "unicode_escape_to_utf8_core_defines.svh"

module ue8_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input ue8_pkg::t_ue8_out o_result
);
    import ue8_pkg::*;

    logic l_out_end, l_stall, l_quiet;
    assign l_out_end = !empty && o_result.string_end;
    assign l_stall   = !empty && !pop;
    // nothing on the output and no request taken at this edge
    assign l_quiet   = empty && !(push && !full);

    // end of string is always the last byte of its run
    `UE8_ASSERT_NOW(a_end_is_run_last, i_clk, i_rst_n, l_out_end, o_result.run_last)

    // a waiting result holds until taken
    `UE8_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, l_stall, !empty && $stable(o_result))

    // out of reset nothing is waiting and input is open
    `UE8_ASSERT_NOW(a_reset_clean, i_clk, i_rst_n, $rose(i_rst_n), empty && !full)

    // an empty decoder that gets nothing stays empty for the next edge
    `UE8_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, $past(l_quiet) && l_quiet, empty)

endmodule

bind unicode_escape_to_utf8_core ue8_checker u_ue8_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for unicode_escape_to_utf8_core.
// Pushes escaped text, predicts the UTF-8 output locally and checks each popped byte.
// Depends on ue8_pkg and the core.
module tb_top;
    import ue8_pkg::*;

    localparam int RAND_ITEMS   = 250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 100;

    typedef enum logic [2:0] {
        PH_IDLE, PH_BSLASH, PH_U, PH_D1, PH_D2, PH_D3
    } t_esc_phase;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    t_ue8_in  i_item  = '0;
    logic     full;
    logic     empty;
    t_ue8_out o_result;

    unicode_escape_to_utf8_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // decoder state as predicted by the bench
    t_esc_phase  esc_phase = PH_IDLE;
    logic [15:0] esc_code  = '0;
    logic [7:0]  esc_chars [4];

    t_ue8_out    utf8_due [$];   // predicted output bytes, oldest first
    t_ue8_out    step_out [$];   // bytes caused by the current input byte
    logic [7:0]  text_buf [$];   // string being assembled for sending
    t_ue8_out    due_head;

    int          err_cnt    = 0;
    int          burst_left = 0;
    int          cycle_cnt  = 0;
    logic [7:0]  pop_mask   = 8'hFF;
    int          pop_tick   = 0;

    function automatic int hex_digit_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void put_byte(logic [7:0] b, logic bad);
        t_ue8_out r;
        r = '0;
        r.out_byte   = b;
        r.bad_escape = bad;
        if (step_out.size() < MAX_BYTES) step_out.insert(step_out.size(), r);
    endfunction

    function automatic void put_raw_escape(int held, logic [7:0] cur);
        put_byte(CHR_BSLASH, 1'b1);
        put_byte(CHR_U, 1'b1);
        for (int i = 0; i < held && i < 4; i++) put_byte(esc_chars[i], 1'b1);
        put_byte(cur, 1'b1);
    endfunction

    function automatic void put_code_point(logic [15:0] cp);
        if (cp <= 16'h007F) begin
            put_byte(cp[7:0], 1'b0);
        end else if (cp <= 16'h07FF) begin
            put_byte({3'b110, cp[10:6]}, 1'b0);
            put_byte({2'b10, cp[5:0]}, 1'b0);
        end else begin
            put_byte({4'b1110, cp[15:12]}, 1'b0);
            put_byte({2'b10, cp[11:6]}, 1'b0);
            put_byte({2'b10, cp[5:0]}, 1'b0);
        end
    endfunction

    // Advance the predicted decoder by one accepted byte and queue its output.
    function automatic void decode_byte(t_ue8_in it);
        logic [7:0] b;
        logic       lst;
        int         held;
        int         hv;
        logic       all_hex;
        b   = it.in_byte;
        lst = it.in_last;
        step_out.delete();
        case (esc_phase)
            PH_IDLE: begin
                if (b == CHR_BSLASH && !lst) esc_phase = PH_BSLASH;
                else put_byte(b, 1'b0);
            end
            PH_BSLASH: begin
                if (b == CHR_U) begin
                    if (lst) begin
                        put_byte(CHR_BSLASH, 1'b1);
                        put_byte(CHR_U, 1'b1);
                    end else begin
                        esc_phase = PH_U;
                        esc_code  = '0;
                    end
                end else if (b == CHR_BSLASH) begin
                    // earlier backslash goes out, the new one stays pending unless the string ends here
                    put_byte(CHR_BSLASH, 1'b0);
                    if (lst) put_byte(CHR_BSLASH, 1'b0);
                end else begin
                    put_byte(CHR_BSLASH, 1'b0);
                    put_byte(b, 1'b0);
                    esc_phase = PH_IDLE;
                end
            end
            PH_U, PH_D1, PH_D2, PH_D3: begin
                held = int'(esc_phase) - int'(PH_U);
                hv   = hex_digit_val(b);
                if (held == 3) begin
                    // fourth character completes the escape even on end of string
                    esc_chars[3] = b;
                    all_hex = 1'b1;
                    for (int i = 0; i < 4; i++)
                        if (hex_digit_val(esc_chars[i]) < 0) all_hex = 1'b0;
                    if (all_hex) put_code_point({esc_code[11:0], hv[3:0]});
                    else put_raw_escape(3, b);
                    esc_phase = PH_IDLE;
                    esc_code  = '0;
                end else if (lst) begin
                    put_raw_escape(held, b);
                    esc_phase = PH_IDLE;
                    esc_code  = '0;
                end else begin
                    esc_chars[held] = b;
                    esc_code  = {esc_code[11:0], (hv < 0) ? 4'h0 : hv[3:0]};
                    esc_phase = t_esc_phase'(esc_phase + 3'd1);
                end
            end
            default: esc_phase = PH_IDLE;
        endcase
        if (lst) esc_phase = PH_IDLE;
        if (step_out.size() > 0) begin
            step_out[step_out.size()-1].run_last   = 1'b1;
            step_out[step_out.size()-1].string_end = lst;
        end
        foreach (step_out[i]) utf8_due.insert(utf8_due.size(), step_out[i]);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + (n - 4'd10);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_digit_val(c) >= 0) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDFFF));   // surrogate halves
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_hex4(logic [15:0] v);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    // Push one request; the sender runs in bursts with random gaps between them.
    task automatic send_byte(logic [7:0] b, logic lst);
        t_ue8_in it;
        it.in_byte = b;
        it.in_last = lst;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        decode_byte(it);
    endtask

    // Send the assembled string, end-of-string flag on its final byte.
    task automatic send_text();
        foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic test_plain_extremes();
        add_byte(8'h00);
        add_byte(8'hFF);
        send_text();
    endtask

    task automatic test_escape_decode();
        add_str("\\uFFFF");
        send_text();
        add_str("\\u07fF");
        send_text();
    endtask

    task automatic test_special_cases();
        add_str("\\\\x");      // repeated backslash, then backslash not followed by u
        send_text();
        add_str("\\");         // lone backslash ends the string
        send_text();
        add_str("\\u1");       // escape cut short by end of string
        send_text();
        add_str("\\u12G4");    // non-hex character inside the escape
        send_text();
    endtask

    task automatic test_random_text();
        int         cnt;
        int         n_tok;
        int         kind;
        int         j;
        logic [7:0] c;
        cnt = 0;
        while (cnt < RAND_ITEMS) begin
            n_tok = $urandom_range(1, 6);
            for (int t = 0; t < n_tok; t++) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    add_str("\\u");
                    add_hex4(pick_code_point());
                end else if (kind < 70) begin
                    repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
                end else if (kind < 78) begin
                    j = $urandom_range(0, 3);
                    add_str("\\u");
                    for (int k = 0; k < 4; k++)
                        add_byte((k == j) ? non_hex_byte()
                                          : hex_char(4'($urandom_range(0, 15))));
                end else if (kind < 84) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHR_U) c = CHR_BSLASH;
                    add_byte(CHR_BSLASH);
                    add_byte(c);
                end else if (kind < 90) begin
                    repeat ($urandom_range(1, 3)) add_byte(CHR_BSLASH);
                    add_str("\\u");
                    add_hex4(pick_code_point());
                end else if (kind < 95) begin
                    // truncated escape: string ends after u or up to three characters
                    add_str("\\u");
                    repeat ($urandom_range(0, 3))
                        add_byte(($urandom_range(0, 3) == 0)
                                 ? non_hex_byte() : hex_char(4'($urandom_range(0, 15))));
                    break;
                end else begin
                    add_byte(CHR_BSLASH);
                    break;
                end
            end
            cnt += text_buf.size();
            send_text();
        end
    endtask

    task automatic report_field(string name, logic [7:0] e, logic [7:0] a);
        if (e !== a) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        end
    endtask

    // Result checker; the receiver stalls on a rotating mask that changes now and then.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (utf8_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t ns: unexpected request, expected none, actual %0h/%0b%0b%0b",
                             $time, o_result.out_byte, o_result.run_last,
                             o_result.string_end, o_result.bad_escape);
            end else begin
                due_head = utf8_due.pop_front();
                report_field("out_byte", due_head.out_byte, o_result.out_byte);
                report_field("run_last", 8'(due_head.run_last), 8'(o_result.run_last));
                report_field("string_end", 8'(due_head.string_end),
                             8'(o_result.string_end));
                report_field("bad_escape", 8'(due_head.bad_escape),
                             8'(o_result.bad_escape));
            end
        end
        if (pop_tick % 48 == 0)
            pop_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        pop <= pop_mask[pop_tick % 8];
        pop_tick++;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d bytes still expected", $time, utf8_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_extremes();
        test_escape_decode();
        test_special_cases();
        test_random_text();
        push <= 1'b0;
        while (utf8_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
